### rtl/core/bfts_pkg.sv
// Shared widths, constants, register indexes and types of the burst transmit-time scheduler.
package bfts_pkg;

   // Field widths.
   localparam int NS_FRAC_BITS   = 16;
   localparam int FRAME_OCTETS_W = 14;
   localparam int GAP_W          = 20;
   localparam int COUNT_W        = 16;
   localparam int SEQ_W          = 48;
   localparam int SEC_W          = 48;
   localparam int NSEC_W         = 30;
   localparam int NPO_W          = 26;
   localparam int CSR_DATA_W     = 48;
   localparam int CSR_INDEX_W    = 3;

   // Arithmetic widths of the time advance.
   localparam int OCTET_SUM_W = GAP_W + 1;
   localparam int PROD_W      = OCTET_SUM_W + NPO_W;
   localparam int TOTAL_W     = PROD_W + 1;
   localparam int WHOLE_W     = TOTAL_W - NS_FRAC_BITS;
   localparam int NSUM_W      = ((WHOLE_W > NSEC_W) ? WHOLE_W : NSEC_W) + 1;
   localparam int CARRY_W     = 2;

   localparam logic [NSUM_W-1:0] ONE_SEC_NS = NSUM_W'(64'd1000000000);
   localparam logic [NSUM_W-1:0] TWO_SEC_NS = NSUM_W'(64'd2000000000);

   // Register reset values.
   localparam logic [FRAME_OCTETS_W-1:0] FRAME_OCTETS_RST  = FRAME_OCTETS_W'(64);
   localparam logic [GAP_W-1:0]          FRAME_GAP_RST     = GAP_W'(12);
   localparam logic [GAP_W-1:0]          BURST_GAP_RST     = GAP_W'(0);
   localparam logic [COUNT_W-1:0]        BURST_LENGTH_RST  = COUNT_W'(1);
   localparam logic [COUNT_W-1:0]        STREAM_LENGTH_RST = COUNT_W'(1);
   localparam logic [SEQ_W-1:0]          TOTAL_LIMIT_RST   = SEQ_W'(0);
   localparam logic [NPO_W-1:0]          NS_PER_OCTET_RST  = NPO_W'(524288);

   // Register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_OCTETS      = 3'd0,
      CSR_FRAME_GAP         = 3'd1,
      CSR_BURST_GAP         = 3'd2,
      CSR_BURST_LENGTH      = 3'd3,
      CSR_STREAM_LENGTH     = 3'd4,
      CSR_TOTAL_FRAME_LIMIT = 3'd5,
      CSR_NS_PER_OCTET      = 3'd6
   } csr_index_type;

   // Operation codes of a request beat.
   localparam logic OP_NEXT_FRAME = 1'b0;
   localparam logic OP_LOAD_TIME  = 1'b1;

   // Configuration as seen by the scheduler core.
   typedef struct packed {
      logic [COUNT_W-1:0] burst_length;
      logic [COUNT_W-1:0] stream_length;
      logic [SEQ_W-1:0]   total_frame_limit;
      logic               interburst_nonzero;
      logic [PROD_W-1:0]  prod_interframe;
      logic [PROD_W-1:0]  prod_interburst;
      logic               busy;
   } cfg_type;

   // One result beat.
   typedef struct packed {
      logic               done_res;
      logic [SEC_W-1:0]   tx_sec;
      logic [NSEC_W-1:0]  tx_nsec;
      logic [SEQ_W-1:0]   seq_number;
      logic [COUNT_W-1:0] frame_in_burst;
      logic [COUNT_W-1:0] burst_in_stream;
   } result_type;

endpackage

### rtl/core/bfts_req_if.sv
// Request channel: operation code and new send time.
interface bfts_req_if;
   logic                        valid;
   logic                        ready;
   logic                        op;
   logic [bfts_pkg::SEC_W-1:0]  new_sec;
   logic [bfts_pkg::NSEC_W-1:0] new_nsec;

   modport source (output valid, output op, output new_sec, output new_nsec, input ready);
   modport sink   (input valid, input op, input new_sec, input new_nsec, output ready);
endinterface

### rtl/core/bfts_rsp_if.sv
// Response channel: done flag or send time, sequence number and positions.
interface bfts_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         done_res;
   logic [bfts_pkg::SEC_W-1:0]   tx_sec;
   logic [bfts_pkg::NSEC_W-1:0]  tx_nsec;
   logic [bfts_pkg::SEQ_W-1:0]   seq_number;
   logic [bfts_pkg::COUNT_W-1:0] frame_in_burst;
   logic [bfts_pkg::COUNT_W-1:0] burst_in_stream;

   modport source (output valid, output done_res, output tx_sec, output tx_nsec,
                   output seq_number, output frame_in_burst, output burst_in_stream,
                   input ready);
   modport sink   (input valid, input done_res, input tx_sec, input tx_nsec,
                   input seq_number, input frame_in_burst, input burst_in_stream,
                   output ready);
endinterface

### rtl/core/burst_frame_tx_time_scheduler.sv
// Top level of the burst transmit-time scheduler: handshake, core and response register.
//
// One request beat is taken per clock; a next-frame request yields its response beat in the
// next cycle from the response register, and a load-time request yields none. Throughput
// is one beat per cycle while the response side takes beats; when it stalls, the response
// register holds and requests wait. The gap times (frame plus gap octets times ns per
// octet) come from two registered multipliers fed by the configuration registers, so
// req_bus.ready is low in the cycle after reset and after each configuration write
// while those products refresh. A done response (limit reached) leaves all state unchanged.
module burst_frame_tx_time_scheduler (
   input  logic                             clock,
   input  logic                             reset,
   bfts_req_if.sink                         req_bus,
   bfts_rsp_if.source                       rsp_bus,
   input  logic                             csr_wr_en,
   input  logic [bfts_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bfts_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import bfts_pkg::*;

   cfg_type    cfg;
   result_type result;
   result_type rsp_data_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       req_accept;
   logic       rsp_load;

   bfts_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Request handshake.
   assign req_bus.ready = !cfg.busy && (!rsp_valid_ff || rsp_bus.ready);
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign rsp_load      = req_accept && (req_bus.op == OP_NEXT_FRAME);

   bfts_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .accept   (req_accept),
      .op       (req_bus.op),
      .new_sec  (req_bus.new_sec),
      .new_nsec (req_bus.new_nsec),
      .result   (result)
   );

   // Response register: loaded by a next-frame beat, emptied when the beat is taken.
   always_comb begin
      priority if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.done_res        = rsp_data_ff.done_res;
   assign rsp_bus.tx_sec          = rsp_data_ff.tx_sec;
   assign rsp_bus.tx_nsec         = rsp_data_ff.tx_nsec;
   assign rsp_bus.seq_number      = rsp_data_ff.seq_number;
   assign rsp_bus.frame_in_burst  = rsp_data_ff.frame_in_burst;
   assign rsp_bus.burst_in_stream = rsp_data_ff.burst_in_stream;

endmodule

### rtl/core/bfts_cfg.sv
// Configuration registers and the registered gap-time products.
module bfts_cfg (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [bfts_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bfts_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output bfts_pkg::cfg_type                   cfg
);
   import bfts_pkg::*;

   logic [FRAME_OCTETS_W-1:0] frame_octets_ff;
   logic [GAP_W-1:0]          frame_gap_ff;
   logic [GAP_W-1:0]          burst_gap_ff;
   logic [COUNT_W-1:0]        burst_length_ff;
   logic [COUNT_W-1:0]        stream_length_ff;
   logic [SEQ_W-1:0]          total_frame_limit_ff;
   logic [NPO_W-1:0]          ns_per_octet_ff;
   logic                      busy_ff;
   logic                      busy_in;
   logic [OCTET_SUM_W-1:0]    octets_if;
   logic [OCTET_SUM_W-1:0]    octets_ib;
   logic [PROD_W-1:0]         prod_if_ff;
   logic [PROD_W-1:0]         prod_if_in;
   logic [PROD_W-1:0]         prod_ib_ff;
   logic [PROD_W-1:0]         prod_ib_in;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_octets_ff      <= FRAME_OCTETS_RST;
         frame_gap_ff         <= FRAME_GAP_RST;
         burst_gap_ff         <= BURST_GAP_RST;
         burst_length_ff      <= BURST_LENGTH_RST;
         stream_length_ff     <= STREAM_LENGTH_RST;
         total_frame_limit_ff <= TOTAL_LIMIT_RST;
         ns_per_octet_ff      <= NS_PER_OCTET_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_OCTETS:      frame_octets_ff      <= csr_wdata[FRAME_OCTETS_W-1:0];
            CSR_FRAME_GAP:         frame_gap_ff         <= csr_wdata[GAP_W-1:0];
            CSR_BURST_GAP:         burst_gap_ff         <= csr_wdata[GAP_W-1:0];
            CSR_BURST_LENGTH:      burst_length_ff      <= csr_wdata[COUNT_W-1:0];
            CSR_STREAM_LENGTH:     stream_length_ff     <= csr_wdata[COUNT_W-1:0];
            CSR_TOTAL_FRAME_LIMIT: total_frame_limit_ff <= csr_wdata[SEQ_W-1:0];
            CSR_NS_PER_OCTET:      ns_per_octet_ff      <= csr_wdata[NPO_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Gap times in fixed-point nanoseconds, refreshed every cycle from the registers.
   assign octets_if  = OCTET_SUM_W'(frame_octets_ff) + OCTET_SUM_W'(frame_gap_ff);
   assign octets_ib  = OCTET_SUM_W'(frame_octets_ff) + OCTET_SUM_W'(burst_gap_ff);
   assign prod_if_in = PROD_W'(octets_if) * PROD_W'(ns_per_octet_ff);
   assign prod_ib_in = PROD_W'(octets_ib) * PROD_W'(ns_per_octet_ff);

   always_ff @(posedge clock) begin
      prod_if_ff <= prod_if_in;
      prod_ib_ff <= prod_ib_in;
   end

   // The products are registered behind the configuration registers, so hold requests off while they refresh.
   assign busy_in = reset | csr_wr_en;

   always_ff @(posedge clock) begin
      busy_ff <= busy_in;
   end

   assign cfg.burst_length       = burst_length_ff;
   assign cfg.stream_length      = stream_length_ff;
   assign cfg.total_frame_limit  = total_frame_limit_ff;
   assign cfg.interburst_nonzero = (burst_gap_ff != '0);
   assign cfg.prod_interframe    = prod_if_ff;
   assign cfg.prod_interburst    = prod_ib_ff;
   assign cfg.busy               = busy_ff;

endmodule

### rtl/core/bfts_core.sv
// Scheduler state: send time, fraction carry, frame count and burst positions.
module bfts_core (
   input  logic                          clock,
   input  logic                          reset,
   input  bfts_pkg::cfg_type             cfg,
   input  logic                          accept,
   input  logic                          op,
   input  logic [bfts_pkg::SEC_W-1:0]    new_sec,
   input  logic [bfts_pkg::NSEC_W-1:0]   new_nsec,
   output bfts_pkg::result_type          result
);
   import bfts_pkg::*;

   logic [SEC_W-1:0]        time_sec_ff,    time_sec_in;
   logic [NSEC_W-1:0]       time_nsec_ff,   time_nsec_in;
   logic [NS_FRAC_BITS-1:0] ns_fraction_ff, ns_fraction_in;
   logic [SEQ_W-1:0]        frames_sent_ff, frames_sent_in;
   logic [COUNT_W-1:0]      frame_pos_ff,   frame_pos_in;
   logic [COUNT_W-1:0]      burst_pos_ff,   burst_pos_in;

   logic                    limit_hit;
   logic [COUNT_W:0]        frame_pos_inc;
   logic [COUNT_W:0]        burst_pos_inc;
   logic                    more_frames;
   logic                    more_bursts;
   logic [COUNT_W-1:0]      adv_frame_pos;
   logic [COUNT_W-1:0]      adv_burst_pos;
   logic [PROD_W-1:0]       gap_prod;
   logic [TOTAL_W-1:0]      total;
   logic [NSUM_W-1:0]       nsum;
   logic [NSUM_W-1:0]       nsum_rem;
   logic [CARRY_W-1:0]      sec_carry;

   // Done once a nonzero limit has been reached.
   assign limit_hit = (cfg.total_frame_limit != '0) &&
                      (frames_sent_ff >= cfg.total_frame_limit);

   // Position update and gap choice.
   assign frame_pos_inc = {1'b0, frame_pos_ff} + (COUNT_W+1)'(1);
   assign burst_pos_inc = {1'b0, burst_pos_ff} + (COUNT_W+1)'(1);
   assign more_frames   = frame_pos_inc < {1'b0, cfg.burst_length};
   assign more_bursts   = burst_pos_inc < {1'b0, cfg.stream_length};

   always_comb begin
      priority if (more_frames) begin
         adv_frame_pos = frame_pos_inc[COUNT_W-1:0];
         adv_burst_pos = burst_pos_ff;
         gap_prod      = cfg.prod_interframe;
      end else if (more_bursts) begin
         adv_frame_pos = '0;
         adv_burst_pos = burst_pos_inc[COUNT_W-1:0];
         gap_prod      = cfg.prod_interburst;
      end else begin
         adv_frame_pos = '0;
         adv_burst_pos = '0;
         gap_prod      = cfg.interburst_nonzero ? cfg.prod_interburst : cfg.prod_interframe;
      end
   end

   // Time advance; the whole nanoseconds stay below three seconds' worth.
   assign total = TOTAL_W'(gap_prod) + TOTAL_W'(ns_fraction_ff);
   assign nsum  = NSUM_W'(time_nsec_ff) + NSUM_W'(total[TOTAL_W-1:NS_FRAC_BITS]);

   always_comb begin
      priority if (nsum >= TWO_SEC_NS) begin
         nsum_rem  = nsum - TWO_SEC_NS;
         sec_carry = CARRY_W'(2);
      end else if (nsum >= ONE_SEC_NS) begin
         nsum_rem  = nsum - ONE_SEC_NS;
         sec_carry = CARRY_W'(1);
      end else begin
         nsum_rem  = nsum;
         sec_carry = '0;
      end
   end

   // Next state.
   always_comb begin
      time_sec_in    = time_sec_ff;
      time_nsec_in   = time_nsec_ff;
      ns_fraction_in = ns_fraction_ff;
      frames_sent_in = frames_sent_ff;
      frame_pos_in   = frame_pos_ff;
      burst_pos_in   = burst_pos_ff;
      if (accept) begin
         if (op == OP_LOAD_TIME) begin
            time_sec_in  = new_sec;
            time_nsec_in = new_nsec;
         end else if (!limit_hit) begin
            time_sec_in    = time_sec_ff + SEC_W'(sec_carry);
            time_nsec_in   = nsum_rem[NSEC_W-1:0];
            ns_fraction_in = total[NS_FRAC_BITS-1:0];
            frames_sent_in = frames_sent_ff + SEQ_W'(1);
            frame_pos_in   = adv_frame_pos;
            burst_pos_in   = adv_burst_pos;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_sec_ff    <= '0;
         time_nsec_ff   <= '0;
         ns_fraction_ff <= '0;
         frames_sent_ff <= '0;
         frame_pos_ff   <= '0;
         burst_pos_ff   <= '0;
      end else begin
         time_sec_ff    <= time_sec_in;
         time_nsec_ff   <= time_nsec_in;
         ns_fraction_ff <= ns_fraction_in;
         frames_sent_ff <= frames_sent_in;
         frame_pos_ff   <= frame_pos_in;
         burst_pos_ff   <= burst_pos_in;
      end
   end

   // Result of a next-frame request: the time before the advance, or done.
   always_comb begin
      if (limit_hit) begin
         result          = '0;
         result.done_res = 1'b1;
      end else begin
         result.done_res        = 1'b0;
         result.tx_sec          = time_sec_ff;
         result.tx_nsec         = time_nsec_ff;
         result.seq_number      = frames_sent_ff;
         result.frame_in_burst  = frame_pos_ff;
         result.burst_in_stream = burst_pos_ff;
      end
   end

endmodule
